// ===== rtl/nrmc_pkg.sv =====
// nrmc_pkg: shared widths, character codes and the RMC template rom
// for the nmea rmc sentence parser; no dependencies
package nrmc_pkg;

  localparam int unsigned CHR_W   = 8;
  localparam int unsigned SHORT_W = 16;
  localparam int unsigned LONG_W  = 32;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned TMPL_LEN = 68;

  // sentence template, first character in the top byte
  localparam logic [CHR_W*TMPL_LEN-1:0] TMPL =
    "$GPRMC,dddtdd.ddm,A,eeae.eeee,l,eeeae.eeee,o,djdk,djdc,dddy??,,,?*??";

  localparam logic [CHR_W-1:0] CHR_DOLLAR = "$";
  localparam logic [CHR_W-1:0] CHR_NORTH  = "N";
  localparam logic [CHR_W-1:0] CHR_EAST   = "E";
  localparam logic [CHR_W-1:0] CHR_DOT    = ".";
  localparam logic [CHR_W-1:0] CHR_ZERO   = "0";
  localparam logic [CHR_W-1:0] CHR_SKIP   = "?";

  // template position codes
  localparam logic [CHR_W-1:0] MODE_SHORT_DIG = "d";
  localparam logic [CHR_W-1:0] MODE_LONG_DIG  = "e";
  localparam logic [CHR_W-1:0] MODE_DEG_DIG   = "a";
  localparam logic [CHR_W-1:0] MODE_TIME      = "t";
  localparam logic [CHR_W-1:0] MODE_MILLIS    = "m";
  localparam logic [CHR_W-1:0] MODE_LAT       = "l";
  localparam logic [CHR_W-1:0] MODE_LON       = "o";
  localparam logic [CHR_W-1:0] MODE_INT_DIG   = "j";
  localparam logic [CHR_W-1:0] MODE_SPEED     = "k";
  localparam logic [CHR_W-1:0] MODE_COURSE    = "c";
  localparam logic [CHR_W-1:0] MODE_DATE      = "y";

  typedef struct packed {
    logic             valid;
    logic [CHR_W-1:0] chr;
  } nrmc_stage_t;

  function automatic logic [CHR_W-1:0] tmpl_char(input logic [POS_W-1:0] pos);
    int unsigned idx;
    logic [CHR_W-1:0] res;
    res = '0;
    if (int'(pos) < TMPL_LEN) begin
      idx = (TMPL_LEN - 1) - int'(pos);
      res = TMPL[idx*CHR_W +: CHR_W];
    end
    return res;
  endfunction

endpackage

// ===== rtl/nrmc_byte_if.sv =====
// nrmc_byte_if: valid/ready channel carrying one received character
// depends on nrmc_pkg
interface nrmc_byte_if;
  import nrmc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CHR_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

// ===== rtl/nrmc_fix_if.sv =====
// nrmc_fix_if: valid/ready channel carrying the latched navigation fields
// depends on nrmc_pkg
interface nrmc_fix_if;
  import nrmc_pkg::*;

  logic               valid;
  logic               ready;
  logic [SHORT_W-1:0] time_hhmm;
  logic [SHORT_W-1:0] millis_of_minute;
  logic signed [LONG_W-1:0] latitude_min;
  logic signed [LONG_W-1:0] longitude_min;
  logic [SHORT_W-1:0] speed_knots;
  logic [SHORT_W-1:0] course_deg;
  logic [SHORT_W-1:0] date_ddmm;
  logic               fix_seen;

  modport source (output valid, output time_hhmm, output millis_of_minute,
                  output latitude_min, output longitude_min, output speed_knots,
                  output course_deg, output date_ddmm, output fix_seen,
                  input ready);
  modport sink (input valid, input time_hhmm, input millis_of_minute,
                input latitude_min, input longitude_min, input speed_knots,
                input course_deg, input date_ddmm, input fix_seen,
                output ready);
endinterface

// ===== rtl/nrmc_input_stage.sv =====
// nrmc_input_stage: input register for received characters
// depends on nrmc_pkg and nrmc_byte_if
module nrmc_input_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  nrmc_byte_if.sink             byte_i,
  input  logic                  take_i,
  output nrmc_pkg::nrmc_stage_t stage_o
);
  import nrmc_pkg::*;

  logic             valid_q, valid_d;
  logic [CHR_W-1:0] chr_q;
  logic             accept;

  // free slot, or the held character leaves this cycle
  assign byte_i.ready = !valid_q || take_i;
  assign accept       = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      chr_q <= byte_i.byte_in;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.chr   = chr_q;

endmodule

// ===== rtl/nrmc_walker.sv =====
// nrmc_walker: template walk, decimal accumulators and latched result fields
// depends on nrmc_pkg and nrmc_fix_if
module nrmc_walker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nrmc_pkg::nrmc_stage_t stage_i,
  output logic                  take_o,
  nrmc_fix_if.source            fix_o
);
  import nrmc_pkg::*;

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [SHORT_W-1:0] short_q, short_d;
  logic [LONG_W-1:0]  long_q, long_d;
  logic [SHORT_W-1:0] time_q, time_d;
  logic [SHORT_W-1:0] millis_q, millis_d;
  logic [LONG_W-1:0]  lat_q, lat_d;
  logic [LONG_W-1:0]  lon_q, lon_d;
  logic [SHORT_W-1:0] speed_q, speed_d;
  logic [SHORT_W-1:0] course_q, course_d;
  logic [SHORT_W-1:0] date_q, date_d;
  logic               fix_q, fix_d;
  logic               out_valid_q, out_valid_d;

  logic               advance;
  logic [CHR_W-1:0]   chr;
  logic [CHR_W-1:0]   dig;
  logic [SHORT_W-1:0] dig_s;
  logic [LONG_W-1:0]  dig_l;
  logic               restart;
  logic [POS_W-1:0]   pos_cur;
  logic [POS_W-1:0]   pos_inc;
  logic [SHORT_W-1:0] short_base;
  logic [SHORT_W-1:0] s_acc;
  logic [LONG_W-1:0]  l_acc10;
  logic [LONG_W-1:0]  l_acc6;
  logic [LONG_W-1:0]  long_neg;
  logic [CHR_W-1:0]   mode;

  // one character per cycle while the result register is free or draining
  assign advance = stage_i.valid && (!out_valid_q || fix_o.ready);
  assign take_o  = advance;

  assign chr        = stage_i.chr;
  assign dig        = chr - CHR_ZERO;
  assign dig_s      = {{(SHORT_W-CHR_W){dig[CHR_W-1]}}, dig};
  assign dig_l      = {{(LONG_W-CHR_W){dig[CHR_W-1]}}, dig};
  assign restart    = (chr == CHR_DOLLAR);
  assign pos_cur    = restart ? '0 : pos_q;
  assign pos_inc    = pos_cur + POS_W'(1);
  assign short_base = restart ? '0 : short_q;
  assign s_acc      = short_base * SHORT_W'(10) + dig_s;
  assign l_acc10    = long_q * LONG_W'(10) + dig_l;
  assign l_acc6     = long_q * LONG_W'(6) + dig_l;
  assign long_neg   = '0 - long_q;
  assign mode       = tmpl_char(pos_cur);

  always_comb begin
    pos_d    = pos_q;
    short_d  = short_q;
    long_d   = long_q;
    time_d   = time_q;
    millis_d = millis_q;
    lat_d    = lat_q;
    lon_d    = lon_q;
    speed_d  = speed_q;
    course_d = course_q;
    date_d   = date_q;
    fix_d    = fix_q;
    if (advance) begin
      short_d = short_base;
      if (int'(pos_cur) >= TMPL_LEN) begin
        pos_d = '0;
      end else begin
        pos_d = pos_inc;
        // exact character match or skip position wins over any code
        if (!(mode == chr || mode == CHR_SKIP)) begin
          case (mode)
            MODE_SHORT_DIG: short_d = s_acc;
            MODE_LONG_DIG:  long_d  = l_acc10;
            MODE_DEG_DIG:   long_d  = l_acc6;
            MODE_TIME: begin
              time_d  = s_acc;
              short_d = '0;
            end
            MODE_MILLIS: begin
              millis_d = s_acc;
              long_d   = '0;
            end
            MODE_LAT: begin
              lat_d  = (chr == CHR_NORTH) ? long_q : long_neg;
              long_d = '0;
            end
            MODE_LON: begin
              lon_d   = (chr == CHR_EAST) ? long_q : long_neg;
              short_d = '0;
            end
            MODE_INT_DIG: begin
              // integer part of variable length: hold position until the dot
              if (chr != CHR_DOT) begin
                short_d = s_acc;
                pos_d   = pos_cur;
              end
            end
            MODE_SPEED: begin
              speed_d = s_acc;
              short_d = '0;
            end
            MODE_COURSE: begin
              course_d = s_acc;
              short_d  = '0;
            end
            MODE_DATE: begin
              date_d = s_acc;
              fix_d  = 1'b1;
            end
            default: pos_d = '0;
          endcase
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (fix_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      short_q     <= '0;
      long_q      <= '0;
      time_q      <= '0;
      millis_q    <= '0;
      lat_q       <= '0;
      lon_q       <= '0;
      speed_q     <= '0;
      course_q    <= '0;
      date_q      <= '0;
      fix_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      short_q     <= short_d;
      long_q      <= long_d;
      time_q      <= time_d;
      millis_q    <= millis_d;
      lat_q       <= lat_d;
      lon_q       <= lon_d;
      speed_q     <= speed_d;
      course_q    <= course_d;
      date_q      <= date_d;
      fix_q       <= fix_d;
      out_valid_q <= out_valid_d;
    end
  end

  // the latched fields only move on advance, so they are the result register
  assign fix_o.valid            = out_valid_q;
  assign fix_o.time_hhmm        = time_q;
  assign fix_o.millis_of_minute = millis_q;
  assign fix_o.latitude_min     = lat_q;
  assign fix_o.longitude_min    = lon_q;
  assign fix_o.speed_knots      = speed_q;
  assign fix_o.course_deg       = course_q;
  assign fix_o.date_ddmm        = date_q;
  assign fix_o.fix_seen         = fix_q;

endmodule

// ===== rtl/nmea_rmc_sentence_parser.sv =====
// nmea_rmc_sentence_parser: top level of the RMC sentence parser
// depends on nrmc_pkg, nrmc_byte_if, nrmc_fix_if, nrmc_input_stage, nrmc_walker
//
// usage:
//   byte_i carries the received sentence one ASCII character per transaction.
//   fix_o carries one transaction per character: the latched time, millis,
//   latitude, longitude, speed, course and date, and the fix_seen flag.
//   a '$' restarts the template walk; a mismatch at a fixed template character
//   goes back to the start. An accepted character waits in the input register,
//   and the walker step then writes its result into the result register.
// throughput: one character per cycle while fix_o is not held, set by the single
//   template walker step between the input register and the result register.
// reset: all latched fields, accumulators and the template position clear
//   to zero, fix_seen is low and both channels are empty.
// stall: while fix_o is held, the result stays in place and one more
//   character waits in the input register; byte_i.ready then drops.
module nmea_rmc_sentence_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  nrmc_byte_if.sink   byte_i,
  nrmc_fix_if.source  fix_o
);
  import nrmc_pkg::*;

  nrmc_stage_t stage;
  logic        take;

  nrmc_input_stage u_input_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .take_i  (take),
    .stage_o (stage)
  );

  nrmc_walker u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .take_o  (take),
    .fix_o   (fix_o)
  );

endmodule

// ===== rtl/nrmc_checker.sv =====
// nrmc_checker: port level assertions for the RMC sentence parser, bound to the top
// depends on nrmc_pkg
module nrmc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [nrmc_pkg::SHORT_W-1:0]     time_hhmm_i,
  input logic [nrmc_pkg::SHORT_W-1:0]     date_ddmm_i,
  input logic signed [nrmc_pkg::LONG_W-1:0] latitude_min_i,
  input logic                             fix_seen_i
);
  import nrmc_pkg::*;

  // fix flag is sticky until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(fix_seen_i) |-> fix_seen_i)
    else $error("fix_seen dropped without reset");

  // date is only ever written together with the fix flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fix_seen_i |-> date_ddmm_i == '0)
    else $error("date latched before fix");

  // latched fields only move when a new result is presented
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> ($stable(time_hhmm_i) && $stable(latitude_min_i)
                      && $stable(date_ddmm_i)))
    else $error("fields changed without a result");

  // a pending result is held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

endmodule

bind nmea_rmc_sentence_parser nrmc_checker u_nrmc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (fix_o.valid),
  .out_ready_i    (fix_o.ready),
  .time_hhmm_i    (fix_o.time_hhmm),
  .date_ddmm_i    (fix_o.date_ddmm),
  .latitude_min_i (fix_o.latitude_min),
  .fix_seen_i     (fix_o.fix_seen)
);
